>>> rtl/core/crwq_pkg.sv
`timescale 1ns / 1ps
// Package for the coalescing ring write queue: operation and status codes.
// Depends on nothing; used by the top level.
package crwq_pkg;

    typedef logic [1:0] t_func;
    typedef logic [1:0] t_status;

    localparam t_func FUNC_ENQ  = 2'd0;
    localparam t_func FUNC_COAL = 2'd1;
    localparam t_func FUNC_DEQ  = 2'd2;
    localparam t_func FUNC_LEN  = 2'd3;

    localparam t_status STATUS_DONE  = 2'd0;
    localparam t_status STATUS_BAD   = 2'd1;
    localparam t_status STATUS_EMPTY = 2'd2;

    localparam int ADDR_BITS = 16;
    localparam int OUT_PAY_BITS = 32;
    localparam int FILL_BITS = 5;
    localparam int FILL_MAX = 31;

endpackage

>>> rtl/core/crwq_mem.sv
`timescale 1ns / 1ps
// Entry store of the queue: one write port and one read port with registered data.
// Depends on nothing; instantiated by the top level.
module crwq_mem #(
    parameter int DEPTH = 64,
    parameter int AW = 6,
    parameter int EW = 48
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [EW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [EW-1:0] o_rd_data
);

    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/coalescing_ring_write_queue.sv
`timescale 1ns / 1ps
// Coalescing ring write queue top level; uses crwq_pkg and crwq_mem.
// A bad channel goes straight to the result; enqueue and length query pass the execute state,
// dequeue also reads the entry store, and coalescing enqueue searches it (one entry read per cycle).
// One transaction at a time: the next is accepted in the cycle after the result is registered,
// which waits while the previous result has not been taken. Synchronous active-low reset
// clears all indexes and counts; the entry store is not cleared.
module coalescing_ring_write_queue
    import crwq_pkg::*;
#(
    parameter int CHANNELS = 4,
    parameter int CAPACITY = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_func,
    input  logic [3:0]              i_channel,
    input  logic [ADDR_BITS-1:0]    i_request_addr,
    input  logic [OUT_PAY_BITS-1:0] i_request_payload,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [1:0]              o_status,
    output logic [ADDR_BITS-1:0]    o_out_addr,
    output logic [OUT_PAY_BITS-1:0] o_out_payload,
    output logic [FILL_BITS-1:0]    o_fill_level
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DEPTH = CHANNELS * CAPACITY;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PB = PAYLOAD_BITS;
    localparam int EW = ADDR_BITS + PB;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_DEQ    = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    logic [2:0]           r_state;
    t_func                r_func;
    logic [CH_W-1:0]      r_ch;
    logic [ADDR_BITS-1:0] r_addr;
    logic [PB-1:0]        r_pay;

    logic [IW-1:0] r_rd_idx [CHANNELS];
    logic [IW-1:0] r_wr_idx [CHANNELS];
    logic [CW-1:0] r_cnt [CHANNELS];

    logic [CW-1:0] r_issue_i;
    logic [IW-1:0] r_issue_pos;
    logic          r_chk_valid;
    logic [IW-1:0] r_chk_pos;

    t_status                r_res_status;
    logic [ADDR_BITS-1:0]   r_res_addr;
    logic [OUT_PAY_BITS-1:0] r_res_pay;
    logic [FILL_BITS-1:0]   r_res_fill;

    logic                    r_out_valid;
    t_status                 r_out_status;
    logic [ADDR_BITS-1:0]    r_out_addr;
    logic [OUT_PAY_BITS-1:0] r_out_pay;
    logic [FILL_BITS-1:0]    r_out_fill;

    logic [IW-1:0]           w_rp;
    logic [IW-1:0]           w_wp;
    logic [CW-1:0]           w_cnt;
    logic                    w_full;
    logic [CW-1:0]           w_app_cnt;
    logic [PB-1:0]           w_in_pay;
    logic [EW-1:0]           w_rdata;
    logic [ADDR_BITS-1:0]    w_rdata_addr;
    logic [OUT_PAY_BITS-1:0] w_rdata_pay;
    logic                    w_hit;
    logic                    w_more;
    logic                    w_mem_rd_en;
    logic [IW-1:0]           w_mem_rd_idx;
    logic                    w_mem_wr_en;
    logic [IW-1:0]           w_mem_wr_idx;

    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] p);
        return (p == IW'(CAPACITY - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [FILL_BITS-1:0] f_fill(input logic [CW-1:0] c);
        if (32'(c) > 32'(FILL_MAX)) begin
            return FILL_BITS'(FILL_MAX);
        end
        return FILL_BITS'(c);
    endfunction

    function automatic logic [AW-1:0] f_maddr(input logic [CH_W-1:0] ch,
                                              input logic [IW-1:0] idx);
        return AW'(int'(ch) * CAPACITY + int'(idx));
    endfunction

    generate
        if (PB <= OUT_PAY_BITS) begin : g_in_narrow
            assign w_in_pay = i_request_payload[PB-1:0];
        end else begin : g_in_wide
            assign w_in_pay = {{(PB - OUT_PAY_BITS){1'b0}}, i_request_payload};
        end
        if (PB >= OUT_PAY_BITS) begin : g_out_wide
            assign w_rdata_pay = w_rdata[OUT_PAY_BITS-1:0];
        end else begin : g_out_narrow
            assign w_rdata_pay = {{(OUT_PAY_BITS - PB){1'b0}}, w_rdata[PB-1:0]};
        end
    endgenerate

    assign w_rdata_addr = w_rdata[EW-1:PB];
    assign w_rp = r_rd_idx[r_ch];
    assign w_wp = r_wr_idx[r_ch];
    assign w_cnt = r_cnt[r_ch];
    assign w_full = (w_cnt == CW'(CAPACITY));
    assign w_app_cnt = w_full ? w_cnt : w_cnt + 1'b1;
    assign w_hit = r_chk_valid && (w_rdata_addr == r_addr);
    assign w_more = (r_issue_i < w_cnt);

    always_comb begin
        w_mem_rd_en = 1'b0;
        w_mem_rd_idx = r_issue_pos;
        w_mem_wr_en = 1'b0;
        w_mem_wr_idx = w_wp;
        case (r_state)
            S_EXEC: begin
                if (r_func == FUNC_ENQ) begin
                    w_mem_wr_en = 1'b1;
                end else if (r_func == FUNC_DEQ && w_cnt != '0) begin
                    w_mem_rd_en = 1'b1;
                    w_mem_rd_idx = w_rp;
                end
            end
            S_SEARCH: begin
                if (w_hit) begin
                    w_mem_wr_en = 1'b1;
                    w_mem_wr_idx = r_chk_pos;
                end else if (w_more) begin
                    w_mem_rd_en = 1'b1;
                end else begin
                    w_mem_wr_en = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    crwq_mem #(
        .DEPTH(DEPTH),
        .AW(AW),
        .EW(EW)
    ) u_mem (
        .i_clk(i_clk),
        .i_wr_en(w_mem_wr_en),
        .i_wr_addr(f_maddr(r_ch, w_mem_wr_idx)),
        .i_wr_data({r_addr, r_pay}),
        .i_rd_en(w_mem_rd_en),
        .i_rd_addr(f_maddr(r_ch, w_mem_rd_idx)),
        .o_rd_data(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
            r_chk_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_rd_idx[i] <= '0;
                r_wr_idx[i] <= '0;
                r_cnt[i] <= '0;
            end
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_RESP) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_func <= i_func;
                        r_ch <= i_channel[CH_W-1:0];
                        r_addr <= i_request_addr;
                        r_pay <= w_in_pay;
                        r_res_status <= STATUS_BAD;
                        r_res_addr <= '0;
                        r_res_pay <= '0;
                        r_res_fill <= '0;
                        if (i_channel >= 4'(CHANNELS)) begin
                            r_state <= S_RESP;
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_EXEC: begin
                    case (r_func)
                        FUNC_ENQ: begin
                            if (w_full) begin
                                r_rd_idx[r_ch] <= f_next(w_rp);
                            end
                            r_wr_idx[r_ch] <= f_next(w_wp);
                            r_cnt[r_ch] <= w_app_cnt;
                            r_res_status <= STATUS_DONE;
                            r_res_fill <= f_fill(w_app_cnt);
                            r_state <= S_RESP;
                        end
                        FUNC_COAL: begin
                            r_res_status <= STATUS_DONE;
                            r_issue_i <= '0;
                            r_issue_pos <= w_rp;
                            r_chk_valid <= 1'b0;
                            r_state <= S_SEARCH;
                        end
                        FUNC_DEQ: begin
                            if (w_cnt == '0) begin
                                r_res_status <= STATUS_EMPTY;
                                r_res_fill <= '0;
                                r_state <= S_RESP;
                            end else begin
                                r_res_status <= STATUS_DONE;
                                r_state <= S_DEQ;
                            end
                        end
                        default: begin
                            r_res_status <= STATUS_DONE;
                            r_res_fill <= f_fill(w_cnt);
                            r_state <= S_RESP;
                        end
                    endcase
                end
                S_SEARCH: begin
                    if (w_hit) begin
                        r_chk_valid <= 1'b0;
                        r_res_fill <= f_fill(w_cnt);
                        r_state <= S_RESP;
                    end else if (w_more) begin
                        r_issue_i <= r_issue_i + 1'b1;
                        r_issue_pos <= f_next(r_issue_pos);
                        r_chk_valid <= 1'b1;
                        r_chk_pos <= r_issue_pos;
                    end else begin
                        r_chk_valid <= 1'b0;
                        if (w_full) begin
                            r_rd_idx[r_ch] <= f_next(w_rp);
                        end
                        r_wr_idx[r_ch] <= f_next(w_wp);
                        r_cnt[r_ch] <= w_app_cnt;
                        r_res_fill <= f_fill(w_app_cnt);
                        r_state <= S_RESP;
                    end
                end
                S_DEQ: begin
                    r_res_addr <= w_rdata_addr;
                    r_res_pay <= w_rdata_pay;
                    r_rd_idx[r_ch] <= f_next(w_rp);
                    r_cnt[r_ch] <= w_cnt - 1'b1;
                    r_res_fill <= f_fill(w_cnt - 1'b1);
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_addr <= r_res_addr;
                        r_out_pay <= r_res_pay;
                        r_out_fill <= r_res_fill;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status = r_out_status;
    assign o_out_addr = r_out_addr;
    assign o_out_payload = r_out_pay;
    assign o_fill_level = r_out_fill;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC || r_state == S_SEARCH || r_state == S_DEQ)
            |-> (32'(w_cnt) <= CAPACITY))
        else $error("channel count exceeds capacity");

    a_wr_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_wr_en |-> (r_state == S_EXEC || r_state == S_SEARCH))
        else $error("entry store written outside an update state");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STATUS_BAD)
            |-> (o_fill_level == '0 && o_out_addr == '0 && o_out_payload == '0))
        else $error("bad channel result carries nonzero fields");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STATUS_EMPTY) |-> (o_fill_level == '0))
        else $error("empty dequeue reports nonzero fill level");

    a_deq_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEQ) |-> (w_cnt != '0 && $past(w_mem_rd_en)))
        else $error("dequeue completes without a prior read");
`endif

endmodule

>>> dv/crwq_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for the coalescing ring write queue: mirrors the per-channel queues,
// predicts each result and compares it with the result transactions. Uses crwq_pkg.
module crwq_scoreboard
    import crwq_pkg::*;
#(
    parameter int CHANNELS = 4,
    parameter int CAPACITY = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [1:0]              i_func,
    input  logic [3:0]              i_channel,
    input  logic [ADDR_BITS-1:0]    i_request_addr,
    input  logic [OUT_PAY_BITS-1:0] i_request_payload,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [1:0]              i_status,
    input  logic [ADDR_BITS-1:0]    i_out_addr,
    input  logic [OUT_PAY_BITS-1:0] i_out_payload,
    input  logic [FILL_BITS-1:0]    i_fill_level,
    output int                      o_mismatch_count,
    output int                      o_pending
);

    typedef struct packed {
        t_status                 status;
        logic [ADDR_BITS-1:0]    addr;
        logic [OUT_PAY_BITS-1:0] payload;
        logic [FILL_BITS-1:0]    fill;
    } t_queue_result;

    localparam logic [OUT_PAY_BITS-1:0] PAY_MASK = OUT_PAY_BITS'(
        (PAYLOAD_BITS >= OUT_PAY_BITS) ? 64'hFFFF_FFFF : ((64'd1 << PAYLOAD_BITS) - 64'd1));

    logic [ADDR_BITS-1:0]    slot_addr [CHANNELS][CAPACITY];
    logic [OUT_PAY_BITS-1:0] slot_pay  [CHANNELS][CAPACITY];
    int                      head_pos  [CHANNELS];
    int                      tail_pos  [CHANNELS];
    int                      live_cnt  [CHANNELS];
    t_queue_result           expected_results [$];
    int                      mismatches = 0;

    assign o_mismatch_count = mismatches;
    assign o_pending = expected_results.size();

    initial begin
        for (int c = 0; c < CHANNELS; c++) begin
            head_pos[c] = 0;
            tail_pos[c] = 0;
            live_cnt[c] = 0;
        end
    end

    function automatic void push_entry(input int ch, input logic [ADDR_BITS-1:0] a,
                                       input logic [OUT_PAY_BITS-1:0] p);
        if (live_cnt[ch] >= CAPACITY) begin
            head_pos[ch] = (head_pos[ch] + 1) % CAPACITY;
            live_cnt[ch]--;
        end
        slot_addr[ch][tail_pos[ch]] = a;
        slot_pay[ch][tail_pos[ch]] = p;
        tail_pos[ch] = (tail_pos[ch] + 1) % CAPACITY;
        live_cnt[ch]++;
    endfunction

    function automatic t_queue_result apply_request(input t_func f, input logic [3:0] ch_in,
                                                    input logic [ADDR_BITS-1:0] a,
                                                    input logic [OUT_PAY_BITS-1:0] p_in);
        t_queue_result r;
        logic [OUT_PAY_BITS-1:0] p;
        int ch;
        int pos;
        bit hit;
        r = '0;
        p = p_in & PAY_MASK;
        ch = int'(ch_in);
        hit = 1'b0;
        if (ch >= CHANNELS) begin
            r.status = STATUS_BAD;
            return r;
        end
        case (f)
            FUNC_ENQ: begin
                push_entry(ch, a, p);
            end
            FUNC_COAL: begin
                pos = head_pos[ch];
                for (int i = 0; i < live_cnt[ch] && !hit; i++) begin
                    if (slot_addr[ch][pos] == a) begin
                        slot_pay[ch][pos] = p;
                        hit = 1'b1;
                    end
                    pos = (pos + 1) % CAPACITY;
                end
                if (!hit) push_entry(ch, a, p);
            end
            FUNC_DEQ: begin
                if (live_cnt[ch] == 0) begin
                    r.status = STATUS_EMPTY;
                    return r;
                end
                r.addr = slot_addr[ch][head_pos[ch]];
                r.payload = slot_pay[ch][head_pos[ch]];
                head_pos[ch] = (head_pos[ch] + 1) % CAPACITY;
                live_cnt[ch]--;
            end
            default: begin
            end
        endcase
        r.status = STATUS_DONE;
        r.fill = (live_cnt[ch] > FILL_MAX) ? FILL_BITS'(FILL_MAX) : FILL_BITS'(live_cnt[ch]);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_queue_result exp_r;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("Unexpected result transaction: status %0d addr %h payload %h fill %0d",
                           i_status, i_out_addr, i_out_payload, i_fill_level);
                    mismatches++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (i_status !== exp_r.status) begin
                        $error("status: expected %0d, actual %0d", exp_r.status, i_status);
                        mismatches++;
                    end
                    if (i_out_addr !== exp_r.addr) begin
                        $error("out_addr: expected %h, actual %h", exp_r.addr, i_out_addr);
                        mismatches++;
                    end
                    if (i_out_payload !== exp_r.payload) begin
                        $error("out_payload: expected %h, actual %h", exp_r.payload,
                               i_out_payload);
                        mismatches++;
                    end
                    if (i_fill_level !== exp_r.fill) begin
                        $error("fill_level: expected %0d, actual %0d", exp_r.fill,
                               i_fill_level);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(apply_request(t_func'(i_func), i_channel,
                                                         i_request_addr, i_request_payload));
            end
        end
    end

endmodule

>>> dv/coalescing_ring_write_queue_tb.sv
`timescale 1ns / 1ps
// Testbench top for the coalescing ring write queue: directed and random request
// transactions with bursty input and stalling output. Uses crwq_pkg and crwq_scoreboard.
module coalescing_ring_write_queue_tb;
    import crwq_pkg::*;

    localparam int CHANNELS = 4;
    localparam int CAPACITY = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int RANDOM_ITEMS = 1330;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic [1:0]              func = FUNC_ENQ;
    logic [3:0]              channel = '0;
    logic [ADDR_BITS-1:0]    request_addr = '0;
    logic [OUT_PAY_BITS-1:0] request_payload = '0;
    logic                    out_ready = 1'b0;
    logic                    in_ready;
    logic                    out_valid;
    logic [1:0]              status;
    logic [ADDR_BITS-1:0]    out_addr;
    logic [OUT_PAY_BITS-1:0] out_payload;
    logic [FILL_BITS-1:0]    fill_level;
    int                      mismatch_count;
    int                      pending;
    int                      burst_left = 0;
    int unsigned             cycle_cnt = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    coalescing_ring_write_queue #(
        .CHANNELS(CHANNELS),
        .CAPACITY(CAPACITY),
        .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_func(func),
        .i_channel(channel),
        .i_request_addr(request_addr),
        .i_request_payload(request_payload),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_status(status),
        .o_out_addr(out_addr),
        .o_out_payload(out_payload),
        .o_fill_level(fill_level)
    );

    crwq_scoreboard #(
        .CHANNELS(CHANNELS),
        .CAPACITY(CAPACITY),
        .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_scoreboard (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .i_in_ready(in_ready),
        .i_func(func),
        .i_channel(channel),
        .i_request_addr(request_addr),
        .i_request_payload(request_payload),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_status(status),
        .i_out_addr(out_addr),
        .i_out_payload(out_payload),
        .i_fill_level(fill_level),
        .o_mismatch_count(mismatch_count),
        .o_pending(pending)
    );

    // The receiver cycles through always-ready, random, sparse and long-stall windows.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        case ((cycle_cnt / 256) % 4)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ((cycle_cnt % 8) < 2);
            default: out_ready <= ((cycle_cnt % 32) >= 20);
        endcase
    end

    task automatic send_request(input t_func f, input logic [3:0] ch,
                                input logic [ADDR_BITS-1:0] a,
                                input logic [OUT_PAY_BITS-1:0] p);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid <= 1'b1;
        func <= f;
        channel <= ch;
        request_addr <= a;
        request_payload <= p;
        do @(posedge i_clk); while (!in_ready);
    endtask

    initial begin
        int sel;
        int phase;
        t_func f;
        logic [3:0] ch;
        logic [ADDR_BITS-1:0] a;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(FUNC_LEN, 4'd0, 16'h0000, 32'h0000_0000);
        send_request(FUNC_DEQ, 4'd0, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(FUNC_ENQ, 4'd4, 16'h1234, 32'h1234_5678);
        send_request(FUNC_DEQ, 4'd15, 16'h0000, 32'h0000_0000);
        send_request(FUNC_ENQ, 4'd0, 16'h0000, 32'h0000_0000);
        send_request(FUNC_ENQ, 4'd0, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(FUNC_COAL, 4'd0, 16'hFFFF, 32'hA5A5_A5A5);
        send_request(FUNC_DEQ, 4'd0, 16'h0000, 32'h0000_0000);
        send_request(FUNC_DEQ, 4'd0, 16'h0000, 32'h0000_0000);
        for (int i = 0; i <= CAPACITY; i++) begin
            send_request(FUNC_ENQ, 4'd3, 16'(i), $urandom);
        end
        send_request(FUNC_COAL, 4'd3, 16'd5, 32'h5A5A_5A5A);
        send_request(FUNC_COAL, 4'd3, 16'h0100, 32'hC3C3_C3C3);
        send_request(FUNC_LEN, 4'd3, 16'h0000, 32'h0000_0000);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            phase = (k / 120) % 3;
            sel = $urandom_range(0, 99);
            case (phase)
                0: f = (sel < 40) ? FUNC_ENQ : (sel < 80) ? FUNC_COAL :
                       (sel < 92) ? FUNC_DEQ : FUNC_LEN;
                1: f = (sel < 15) ? FUNC_ENQ : (sel < 30) ? FUNC_COAL :
                       (sel < 90) ? FUNC_DEQ : FUNC_LEN;
                default: f = (sel < 30) ? FUNC_ENQ : (sel < 60) ? FUNC_COAL :
                             (sel < 90) ? FUNC_DEQ : FUNC_LEN;
            endcase
            ch = ($urandom_range(0, 99) < 88) ? 4'($urandom_range(0, CHANNELS - 1))
                                              : 4'($urandom_range(CHANNELS, 15));
            a = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 11)) : 16'($urandom);
            send_request(f, ch, a, $urandom);
        end
        in_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
